// File: rtl/core/frr_pkg.sv
// Shared types and constants of the framed result receiver.
`timescale 1ns / 1ps
`default_nettype none
package frr_pkg;

	// Configuration port address width: five registers at byte addresses 4*i.
	localparam int AddrW = 5;
	localparam int EvW   = 3;

	typedef struct packed {
		logic [7:0] protocol_version;
		logic [7:0] target_code;
		logic [7:0] result_command;
		logic [5:0] result_payload_length;
		logic [5:0] max_payload_length;
	} cfg_t;

	// Decoded fields of the last accepted frame.
	typedef struct packed {
		logic        [15:0] sweep_no;
		logic        [15:0] point_no;
		logic        [63:0] frequency_millihertz;
		logic        [31:0] dds_tuning_word;
		logic        [31:0] sample_rate;
		logic        [15:0] transform_len;
		logic        [15:0] bin_no;
		logic signed [31:0] real_part;
		logic signed [31:0] imag_part;
		logic        [23:0] exponent_and_overrange;
		logic        [23:0] status_and_sequence;
	} held_t;

endpackage
`default_nettype wire

// File: rtl/core/frr_if.sv
// Channel interfaces of the framed result receiver: received bytes and results.
`timescale 1ns / 1ps
`default_nettype none
interface frr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface frr_result_if;
	logic              valid;
	logic              ready;
	logic        [2:0] event_res;
	logic       [15:0] sweep_no;
	logic       [15:0] point_no;
	logic       [63:0] frequency_millihertz;
	logic       [31:0] dds_tuning_word;
	logic       [31:0] sample_rate;
	logic       [15:0] transform_len;
	logic       [15:0] bin_no;
	logic signed [31:0] real_part;
	logic signed [31:0] imag_part;
	logic       [23:0] exponent_and_overrange;
	logic       [23:0] status_and_sequence;

	modport source (
		output valid, input ready, output event_res, output sweep_no, output point_no,
		output frequency_millihertz, output dds_tuning_word, output sample_rate,
		output transform_len, output bin_no, output real_part, output imag_part,
		output exponent_and_overrange, output status_and_sequence
	);
	modport sink (
		input valid, output ready, input event_res, input sweep_no, input point_no,
		input frequency_millihertz, input dds_tuning_word, input sample_rate,
		input transform_len, input bin_no, input real_part, input imag_part,
		input exponent_and_overrange, input status_and_sequence
	);
endinterface
`default_nettype wire

// File: rtl/core/frr_cfg.sv
// APB-style configuration registers of the framed result receiver.
`timescale 1ns / 1ps
`default_nettype none
module frr_cfg (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [frr_pkg::AddrW-1:0] paddr,
	input  wire logic [31:0]              pwdata,
	output logic      [31:0]              prdata,
	output logic                          pready,
	output frr_pkg::cfg_t                 cfg
);
	import frr_pkg::*;

	localparam logic [AddrW-3:0] RegVersion = 3'd0;
	localparam logic [AddrW-3:0] RegTarget  = 3'd1;
	localparam logic [AddrW-3:0] RegCommand = 3'd2;
	localparam logic [AddrW-3:0] RegResLen  = 3'd3;
	localparam logic [AddrW-3:0] RegMaxLen  = 3'd4;

	cfg_t             cfg_q;
	logic             wr_en;
	logic [AddrW-3:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[AddrW-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.protocol_version      <= 8'h01;
			cfg_q.target_code           <= 8'h00;
			cfg_q.result_command        <= 8'h00;
			cfg_q.result_payload_length <= 6'd37;
			cfg_q.max_payload_length    <= 6'd51;
		end else if (wr_en) begin
			unique case (reg_idx)
				RegVersion: cfg_q.protocol_version      <= pwdata[7:0];
				RegTarget:  cfg_q.target_code           <= pwdata[7:0];
				RegCommand: cfg_q.result_command        <= pwdata[7:0];
				RegResLen:  cfg_q.result_payload_length <= pwdata[5:0];
				RegMaxLen:  cfg_q.max_payload_length    <= pwdata[5:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			RegVersion: prdata = {24'd0, cfg_q.protocol_version};
			RegTarget:  prdata = {24'd0, cfg_q.target_code};
			RegCommand: prdata = {24'd0, cfg_q.result_command};
			RegResLen:  prdata = {26'd0, cfg_q.result_payload_length};
			RegMaxLen:  prdata = {26'd0, cfg_q.max_payload_length};
			default:    prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/core/frr_parser.sv
// Frame parser: header hunt, CRC-16/CCITT-FALSE, frame checks and result capture.
`timescale 1ns / 1ps
`default_nettype none
module frr_parser #(
	parameter int FRAME_BUFFER_BYTES = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [7:0]             rx_byte,
	input  wire frr_pkg::cfg_t          cfg,
	output logic [frr_pkg::EvW-1:0]     event_res,
	output frr_pkg::held_t              held
);
	import frr_pkg::*;

	localparam logic [1:0] PhHunt  = 2'd0;
	localparam logic [1:0] PhSync2 = 2'd1;
	localparam logic [1:0] PhFixed = 2'd2;
	localparam logic [1:0] PhRest  = 2'd3;

	localparam logic [EvW-1:0] EvIgnored  = 3'd0;
	localparam logic [EvW-1:0] EvConsumed = 3'd1;
	localparam logic [EvW-1:0] EvAccept   = 3'd2;
	localparam logic [EvW-1:0] EvLenErr   = 3'd3;
	localparam logic [EvW-1:0] EvTailErr  = 3'd4;
	localparam logic [EvW-1:0] EvCrcErr   = 3'd5;
	localparam logic [EvW-1:0] EvHdrErr   = 3'd6;

	localparam logic [7:0]  SyncA    = 8'hF9;
	localparam logic [7:0]  SyncB    = 8'h26;
	localparam logic [7:0]  EndA     = 8'h62;
	localparam logic [7:0]  EndB     = 8'h9F;
	localparam logic [15:0] CrcPoly  = 16'h1021;
	localparam logic [15:0] CrcInit  = 16'hFFFF;

	// Longest frame is 13 overhead bytes plus a 63-byte payload.
	localparam int PosW        = 7;
	localparam int FixedLen    = 9;
	localparam int OverheadLen = 13;
	// Frame offsets that land in the result fields: payload bytes 0..36.
	localparam int ShadowBase  = 9;
	localparam int ShadowBytes = 37;
	localparam int PosVersion  = 2;
	localparam int PosTarget   = 3;
	localparam int PosCommand  = 4;
	localparam int PosSequence = 6;
	localparam int PosLenLo    = 7;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] x;
		x = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			x = x[15] ? ((x << 1) ^ CrcPoly) : (x << 1);
		end
		return x;
	endfunction

	logic [1:0]      phase_q, phase_d;
	logic [PosW-1:0] pos_q, pos_d, pos_inc, pos_plus4;
	logic [PosW-1:0] exp_q, exp_d;
	logic [15:0]     crc_q, crc_d, crc_next;
	logic [7:0]      ver_q, tgt_q, cmd_q, seq_q, len_lo_q;
	logic [5:0]      plen_q;
	logic [7:0]      h1_q, h2_q, h3_q;
	logic [15:0]     plen_full;
	logic            buf_full;
	logic            capture;
	logic            shadow_wr;
	logic [7:0]      shadow_q [ShadowBytes];
	logic [7:0]      shadow_d [ShadowBytes];
	held_t           held_q, held_cap;

	assign pos_inc   = pos_q + PosW'(1);
	assign pos_plus4 = pos_q + PosW'(4);
	assign plen_full = {rx_byte, len_lo_q};
	assign crc_next  = crc_byte(crc_q, rx_byte);
	assign buf_full  = int'(pos_q) >= FRAME_BUFFER_BYTES;
	assign shadow_wr = step && (phase_q == PhRest) && !buf_full;
	assign held      = held_q;

	always_comb begin
		for (int k = 0; k < ShadowBytes; k++) begin
			shadow_d[k] = (shadow_wr && (pos_q == PosW'(ShadowBase + k))) ?
				rx_byte : shadow_q[k];
		end
	end

	// Result fields are taken from the store image including the final byte.
	always_comb begin
		held_cap.sweep_no             = {shadow_d[1], shadow_d[0]};
		held_cap.point_no             = {shadow_d[3], shadow_d[2]};
		held_cap.frequency_millihertz = {shadow_d[11], shadow_d[10], shadow_d[9],
			shadow_d[8], shadow_d[7], shadow_d[6], shadow_d[5], shadow_d[4]};
		held_cap.dds_tuning_word      = {shadow_d[15], shadow_d[14], shadow_d[13],
			shadow_d[12]};
		held_cap.sample_rate          = {shadow_d[19], shadow_d[18], shadow_d[17],
			shadow_d[16]};
		held_cap.transform_len        = {shadow_d[21], shadow_d[20]};
		held_cap.bin_no               = {shadow_d[23], shadow_d[22]};
		held_cap.real_part            = {shadow_d[27], shadow_d[26], shadow_d[25],
			shadow_d[24]};
		held_cap.imag_part            = {shadow_d[31], shadow_d[30], shadow_d[29],
			shadow_d[28]};
		held_cap.exponent_and_overrange = {shadow_d[32], shadow_d[34], shadow_d[33]};
		held_cap.status_and_sequence    = {shadow_d[36], shadow_d[35], seq_q};
	end

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		exp_d     = exp_q;
		crc_d     = crc_q;
		event_res = EvConsumed;
		capture   = 1'b0;
		unique case (phase_q)
			PhHunt: begin
				if (rx_byte == SyncA) begin
					pos_d   = PosW'(1);
					crc_d   = CrcInit;
					phase_d = PhSync2;
				end else begin
					event_res = EvIgnored;
				end
			end
			PhSync2: begin
				if (rx_byte == SyncB) begin
					pos_d   = PosW'(2);
					crc_d   = CrcInit;
					phase_d = PhFixed;
				end else if (rx_byte == SyncA) begin
					pos_d = PosW'(1);
				end else begin
					phase_d = PhHunt;
					pos_d   = '0;
					exp_d   = '0;
					crc_d   = CrcInit;
				end
			end
			PhFixed: begin
				pos_d = pos_inc;
				crc_d = crc_next;
				if (pos_inc >= PosW'(FixedLen)) begin
					if (plen_full > {10'd0, cfg.max_payload_length}) begin
						event_res = EvLenErr;
						phase_d   = PhHunt;
						pos_d     = '0;
						exp_d     = '0;
						crc_d     = CrcInit;
					end else begin
						exp_d   = PosW'(OverheadLen) + PosW'(plen_full[5:0]);
						phase_d = PhRest;
					end
				end
			end
			PhRest: begin
				if (buf_full) begin
					event_res = EvLenErr;
					phase_d   = PhHunt;
					pos_d     = '0;
					exp_d     = '0;
					crc_d     = CrcInit;
				end else begin
					// The CRC covers the payload but not the CRC field or tail.
					if (pos_plus4 < exp_q) begin
						crc_d = crc_next;
					end
					pos_d = pos_inc;
					if (pos_inc >= exp_q) begin
						phase_d = PhHunt;
						pos_d   = '0;
						exp_d   = '0;
						crc_d   = CrcInit;
						if (h1_q != EndA || rx_byte != EndB) begin
							event_res = EvTailErr;
						end else if ({h2_q, h3_q} != crc_q) begin
							event_res = EvCrcErr;
						end else if (ver_q != cfg.protocol_version ||
								tgt_q != cfg.target_code ||
								cmd_q != cfg.result_command ||
								plen_q != cfg.result_payload_length) begin
							event_res = EvHdrErr;
						end else begin
							event_res = EvAccept;
							capture   = 1'b1;
						end
					end
				end
			end
			default: begin
				phase_d = PhHunt;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhHunt;
			pos_q   <= '0;
			exp_q   <= '0;
			crc_q   <= CrcInit;
			held_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			exp_q   <= exp_d;
			crc_q   <= crc_d;
			if (capture) begin
				held_q <= held_cap;
			end
		end
	end

	// Header bytes, byte history and the result-field image need no reset.
	always_ff @(posedge clk) begin
		shadow_q <= shadow_d;
		if (step) begin
			h1_q <= rx_byte;
			h2_q <= h1_q;
			h3_q <= h2_q;
			if (phase_q == PhFixed) begin
				if (pos_q == PosW'(PosVersion)) ver_q <= rx_byte;
				if (pos_q == PosW'(PosTarget)) tgt_q <= rx_byte;
				if (pos_q == PosW'(PosCommand)) cmd_q <= rx_byte;
				if (pos_q == PosW'(PosSequence)) seq_q <= rx_byte;
				if (pos_q == PosW'(PosLenLo)) len_lo_q <= rx_byte;
				if (pos_inc >= PosW'(FixedLen)) plen_q <= plen_full[5:0];
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/framed_result_receiver.sv
// Top level of the framed result receiver: byte input stage, parser, result register.
//
// Channel  Role   Handshake        Payload
// rx       sink   valid / ready    rx_byte
// res      source valid / ready    event_res and the held result fields
// apb      slave  psel / penable   five registers of up to 8 bits at byte address 4*i
//
// One item per clock unless res stalls: a byte is registered, then parsed, and its
// result lands in the output register. The input stage keeps accepting while a
// result waits, until both stages are full. The parser state, the CRC and the
// held result are cleared by arst_n; the held fields read zero until the first
// accepted frame. A stalled result holds both its event and its fields.
`timescale 1ns / 1ps
`default_nettype none
module framed_result_receiver #(
	parameter int FRAME_BUFFER_BYTES = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	frr_byte_if.sink                       rx,
	frr_result_if.source                   res,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [frr_pkg::AddrW-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready
);
	import frr_pkg::*;

	cfg_t           cfg;
	held_t          held;
	logic           byte_valid_s1;
	logic [7:0]     byte_s1;
	logic           advance;
	logic [EvW-1:0] event_d;
	logic           res_valid_q;
	logic [EvW-1:0] event_q;

	frr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	frr_parser #(
		.FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.event_res (event_d),
		.held      (held)
	);

	// The staged byte moves on when the result register is empty or being read.
	assign advance  = byte_valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (rx.ready) begin
				byte_valid_s1 <= rx.valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
		if (advance) begin
			event_q <= event_d;
		end
	end

	// The held fields change only on an advance, together with the event.
	assign res.valid                  = res_valid_q;
	assign res.event_res              = event_q;
	assign res.sweep_no               = held.sweep_no;
	assign res.point_no               = held.point_no;
	assign res.frequency_millihertz   = held.frequency_millihertz;
	assign res.dds_tuning_word        = held.dds_tuning_word;
	assign res.sample_rate            = held.sample_rate;
	assign res.transform_len          = held.transform_len;
	assign res.bin_no                 = held.bin_no;
	assign res.real_part              = held.real_part;
	assign res.imag_part              = held.imag_part;
	assign res.exponent_and_overrange = held.exponent_and_overrange;
	assign res.status_and_sequence    = held.status_and_sequence;
endmodule
`default_nettype wire
